// ----- src/scope_column_decimator_defines.svh -----
// Assertion helpers for the scope column decimator
`ifndef SCOPE_COLUMN_DECIMATOR_DEFINES_SVH
`define SCOPE_COLUMN_DECIMATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// antecedent implies consequent in the next cycle
`define SCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ----- src/scd_pkg.sv -----
package scd_pkg;

  localparam logic [2:0] MODE_FIRST  = 3'd0;
  localparam logic [2:0] MODE_MINMAX = 3'd1;
  localparam logic [2:0] MODE_AVG    = 3'd2;
  localparam logic [2:0] MODE_MAVG   = 3'd3;
  localparam logic [2:0] MODE_PASS   = 3'd4;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_SPP  = 2'd2;

  localparam int WIN_LEN = 5;

  // job handed from front to back
  typedef struct packed {
    logic        divide;     // column average needs a divide
    logic        mavg;       // moving-average job
    logic [2:0]  n_out;      // results in this job (0..5; jobs with none are not queued)
    logic        first_avg;  // first result is the full-window average
    logic        flush;      // tail results follow
    logic        frame_end;
    logic [15:0] a1;         // sum or point, channel one
    logic [15:0] a2;
    logic [15:0] w0;         // window words, oldest first
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [15:0] w4;
    logic [2:0]  cnt;        // valid window words
    logic [8:0]  spp;
  } job_t;

  typedef struct packed {
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic        frame_last;
    logic        step_last;
  } res_t;

endpackage

// ----- src/scd_front.sv -----
module scd_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_SAMPLES_PER_PIXEL = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [10:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       raw1,
  input  logic [7:0]       raw2,
  output logic             job_valid,
  input  logic             job_ready,
  output scd_pkg::job_t    job,
  output logic             restart
);
  import scd_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [2:0]    mode_r;
  logic [10:0]   cols_cfg_r;
  logic [8:0]    spp_cfg_r;
  logic [11:0]   col_r, col_nxt;
  logic [8:0]    smp_r, smp_nxt;
  logic          phase_r, phase_nxt;
  logic [15:0]   s1_r, s1_nxt, s2_r, s2_nxt;
  logic [7:0]    e1_r, e1_nxt, e2_r, e2_nxt;
  logic [15:0]   win_r [4];
  logic [15:0]   win_nxt [4];
  logic [2:0]    fill_r, fill_nxt;
  logic [10:0]   cols;
  logic [8:0]    spp;
  logic [7:0]    v1, v2;
  logic          first, col_end, last_col, frame_end, acc;
  logic [15:0]   l [5];
  logic [2:0]    cnt;
  job_t          j;

  assign restart = cfg_we && (cfg_idx == REG_MODE || cfg_idx == REG_COLS ||
                              cfg_idx == REG_SPP);
  assign in_ready = job_ready;
  assign acc = in_valid && in_ready;
  assign job_valid = acc;
  assign job = j;

  // effective counts
  always_comb begin
    cols = cols_cfg_r;
    if (cols == 11'd0) cols = 11'd1;
    if ({1'b0, cols} > CW'(MAX_COLUMNS) && MAX_COLUMNS < 2048) cols = 11'(MAX_COLUMNS);
    spp = spp_cfg_r;
    if (spp == 9'd0) spp = 9'd1;
    if (spp > 9'(MAX_SAMPLES_PER_PIXEL)) spp = 9'(MAX_SAMPLES_PER_PIXEL);
  end

  // classify the sample and build the job
  always_comb begin
    v1 = ~raw1;
    v2 = ~raw2;
    first = (smp_r == 9'd0);
    col_end = (smp_r + 9'd1 >= spp);
    last_col = (col_r + 12'd1 >= {1'b0, cols});
    frame_end = col_end && last_col;
    col_nxt = col_r; smp_nxt = smp_r; phase_nxt = phase_r;
    s1_nxt = s1_r; s2_nxt = s2_r; e1_nxt = e1_r; e2_nxt = e2_r;
    for (int i = 0; i < 4; i++) win_nxt[i] = win_r[i];
    fill_nxt = fill_r;
    for (int i = 0; i < 4; i++) l[i] = win_r[i];
    l[4] = '0;
    cnt = (fill_r > 3'd4) ? 3'd4 : fill_r;
    j = '0;
    j.spp = spp;
    j.frame_end = frame_end;
    j.a1 = {8'd0, v1};
    j.a2 = {8'd0, v2};
    unique case (mode_r)
      MODE_FIRST: begin
        j.n_out = first ? 3'd1 : 3'd0;
        j.frame_end = last_col;
      end
      MODE_MINMAX: begin
        if (first) begin
          e1_nxt = v1; e2_nxt = v2;
        end else if (!phase_r) begin
          if (v1 < e1_r) e1_nxt = v1;
          if (v2 < e2_r) e2_nxt = v2;
        end else begin
          if (v1 > e1_r) e1_nxt = v1;
          if (v2 > e2_r) e2_nxt = v2;
        end
        j.a1 = {8'd0, e1_nxt};
        j.a2 = {8'd0, e2_nxt};
        j.n_out = col_end ? 3'd1 : 3'd0;
        if (col_end) phase_nxt = ~phase_r;
      end
      MODE_AVG: begin
        s1_nxt = first ? {8'd0, v1} : s1_r + {8'd0, v1};
        s2_nxt = first ? {8'd0, v2} : s2_r + {8'd0, v2};
        j.a1 = s1_nxt;
        j.a2 = s2_nxt;
        j.divide = 1'b1;
        j.n_out = col_end ? 3'd1 : 3'd0;
      end
      MODE_MAVG: begin
        l[cnt] = {v2, v1};
        j.mavg = 1'b1;
        j.w0 = l[0]; j.w1 = l[1]; j.w2 = l[2]; j.w3 = l[3]; j.w4 = l[4];
        j.cnt = cnt + 3'd1;
        j.first_avg = (cnt == 3'd4);
        j.flush = frame_end;
        if (cnt == 3'd4) begin
          for (int i = 0; i < 4; i++) win_nxt[i] = l[i+1];
          fill_nxt = 3'd4;
        end else begin
          for (int i = 0; i < 4; i++) win_nxt[i] = l[i];
          fill_nxt = cnt + 3'd1;
        end
        j.n_out = frame_end ? ((cnt == 3'd4) ? 3'd5 : cnt + 3'd1)
                            : ((cnt == 3'd4) ? 3'd1 : 3'd0);
        if (frame_end) fill_nxt = 3'd0;
      end
      default: begin
        j.n_out = 3'd1;
      end
    endcase
    if (col_end) begin
      smp_nxt = 9'd0;
      if (frame_end) begin
        col_nxt = 12'd0;
        phase_nxt = 1'b0;
        fill_nxt = 3'd0;
      end else begin
        col_nxt = col_r + 12'd1;
      end
    end else begin
      smp_nxt = smp_r + 9'd1;
    end
  end

  // configuration and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIRST;
      cols_cfg_r <= 11'd1;
      spp_cfg_r <= 9'd1;
      col_r <= '0; smp_r <= '0; phase_r <= 1'b0;
      s1_r <= '0; s2_r <= '0; e1_r <= '0; e2_r <= '0;
      fill_r <= '0;
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else if (restart) begin
      unique case (cfg_idx)
        REG_MODE: mode_r <= cfg_data[2:0];
        REG_COLS: cols_cfg_r <= cfg_data;
        REG_SPP:  spp_cfg_r <= cfg_data[8:0];
        default: ;
      endcase
      col_r <= '0; smp_r <= '0; phase_r <= 1'b0;
      s1_r <= '0; s2_r <= '0; e1_r <= '0; e2_r <= '0;
      fill_r <= '0;
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else if (acc) begin
      col_r <= col_nxt; smp_r <= smp_nxt; phase_r <= phase_nxt;
      s1_r <= s1_nxt; s2_r <= s2_nxt; e1_r <= e1_nxt; e2_r <= e2_nxt;
      fill_r <= fill_nxt;
      for (int i = 0; i < 4; i++) win_r[i] <= win_nxt[i];
    end
  end

endmodule

// ----- src/scd_queue.sv -----
module scd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           flush,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  scd_pkg::job_t  wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output scd_pkg::job_t  rd_job
);
  import scd_pkg::*;

  // two-word queue between classifier and executor
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && wr_ready && (wr_job.n_out != 3'd0);
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- src/scd_back.sv -----
module scd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           restart,
  input  logic           job_valid,
  output logic           job_ready,
  input  scd_pkg::job_t  job,
  output logic           out_valid,
  input  logic           out_ready,
  output scd_pkg::res_t  res,
  output logic [17:0]    pidx
);
  import scd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  st_r, st_nxt;
  job_t        j_r;
  logic [2:0]  k_r;      // results given so far
  logic [3:0]  dbit_r;   // divide bit position
  logic [15:0] q1_r, q2_r;
  logic [8:0]  r1_r, r2_r;
  logic [17:0] pc_r;
  logic        ov_r;
  res_t        res_r;
  logic [17:0] pidx_r;
  logic [9:0]  t1, t2;
  logic [10:0] ws1, ws2;
  logic [2:0]  from;
  logic [15:0] w [5];
  logic [7:0]  m1, m2;
  logic        last_one, can_emit;

  assign out_valid = ov_r;
  assign res = res_r;
  assign pidx = pidx_r;
  assign can_emit = !ov_r || out_ready;
  assign job_ready = (st_r == ST_IDLE);

  // restoring divide step for both channels
  always_comb begin
    t1 = {r1_r, j_r.a1[dbit_r]} ;
    t2 = {r2_r, j_r.a2[dbit_r]};
  end

  // window sum for the current result
  always_comb begin
    w[0] = j_r.w0; w[1] = j_r.w1; w[2] = j_r.w2; w[3] = j_r.w3; w[4] = j_r.w4;
    from = j_r.first_avg ? ((k_r == 3'd0) ? 3'd0 : k_r) : k_r;
    ws1 = '0; ws2 = '0;
    for (int i = 0; i < 5; i++) begin
      if (3'(i) >= from && 3'(i) < j_r.cnt) begin
        ws1 = ws1 + {3'd0, w[i][7:0]};
        ws2 = ws2 + {3'd0, w[i][15:8]};
      end
    end
    // divide by five: 3277 / 2^14 is exact for sums up to 5 * 255
    m1 = 8'((23'(ws1) * 23'd3277) >> 14);
    m2 = 8'((23'(ws2) * 23'd3277) >> 14);
    last_one = (k_r + 3'd1 == j_r.n_out);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (job_valid) st_nxt = job.divide ? ST_DIV : ST_EMIT;
      ST_DIV:  if (dbit_r == 4'd0) st_nxt = ST_EMIT;
      ST_EMIT: if (can_emit && last_one) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      pc_r <= '0;
      k_r <= '0;
      dbit_r <= '0;
    end else begin
      st_r <= st_nxt;
      // output word held until taken
      if (st_r == ST_EMIT && can_emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (job_valid) begin
          j_r <= job;
          k_r <= '0;
          dbit_r <= 4'd15;
          r1_r <= '0; r2_r <= '0;
        end
        ST_DIV: begin
          if ({1'b0, t1} >= {2'b0, j_r.spp}) begin
            r1_r <= 9'(t1 - {1'b0, j_r.spp}); q1_r[dbit_r] <= 1'b1;
          end else begin
            r1_r <= t1[8:0]; q1_r[dbit_r] <= 1'b0;
          end
          if ({1'b0, t2} >= {2'b0, j_r.spp}) begin
            r2_r <= 9'(t2 - {1'b0, j_r.spp}); q2_r[dbit_r] <= 1'b1;
          end else begin
            r2_r <= t2[8:0]; q2_r[dbit_r] <= 1'b0;
          end
          dbit_r <= dbit_r - 4'd1;
        end
        ST_EMIT: if (can_emit) begin
          pidx_r <= pc_r;
          res_r.step_last <= last_one;
          if (j_r.mavg) begin
            res_r.p1 <= m1;
            res_r.p2 <= m2;
            res_r.frame_last <= (j_r.first_avg && k_r == 3'd0) ? 1'b0 :
                                (j_r.flush && last_one);
          end else if (j_r.divide) begin
            res_r.p1 <= q1_r[7:0];
            res_r.p2 <= q2_r[7:0];
            res_r.frame_last <= j_r.frame_end;
          end else begin
            res_r.p1 <= j_r.a1[7:0];
            res_r.p2 <= j_r.a2[7:0];
            res_r.frame_last <= j_r.frame_end;
          end
          k_r <= k_r + 3'd1;
          if (last_one && j_r.frame_end && (j_r.mavg ? j_r.flush : 1'b1)
              && !(j_r.mavg == 1'b0 && j_r.divide == 1'b0 && j_r.frame_end == 1'b0))
            pc_r <= '0;
          else
            pc_r <= pc_r + 18'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/scope_column_decimator.sv -----
// Channel  | Direction | Contents
// in_      | slave     | tdata: ch1_raw, ch2_raw
// out_     | master    | tdata: ch1_point, ch2_point, point_index; tuser: frame_last, step_last
// cfg_     | write     | index 0 mode, 1 column count, 2 samples per pixel
// A sample word is classified in its accept cycle; the front stalls when the job queue is full.
// The back end loads a job while idle and gives all its result words before taking another.
// Column averages first pass through the bit-serial divider, one quotient bit per cycle.
// A moving-average frame tail gives up to five words; out_tready low holds the output word.
// Reset (rst_n low, synchronous) and any register write restart the frame and drop queued work.
module scope_column_decimator #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_SAMPLES_PER_PIXEL = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ch1_raw, ch2_raw
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // ch1_point, ch2_point, point_index, zero fill
  output logic [1:0]  out_tuser   // frame_last, step_last
);
  import scd_pkg::*;

  `include "scope_column_decimator_defines.svh"

  logic          restart, fj_valid, fj_ready, bj_valid, bj_ready;
  job_t          fj, bj;
  res_t          res;
  logic [17:0]   pidx;

  scd_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_SAMPLES_PER_PIXEL(MAX_SAMPLES_PER_PIXEL)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .raw1(in_tdata[7:0]), .raw2(in_tdata[15:8]),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj), .restart
  );

  scd_queue u_queue (
    .clk, .rst_n, .flush(restart),
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  scd_back u_back (
    .clk, .rst_n, .restart,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(out_tvalid), .out_ready(out_tready), .res, .pidx
  );

  assign out_tdata = {6'd0, pidx, res.p2, res.p1};
  assign out_tuser = {res.step_last, res.frame_last};

  `SCD_ASSERT_IMP(a_fl_step, out_tvalid && out_tuser[0], out_tuser[1])
  `SCD_ASSERT_NXT(a_fl_zero, out_tvalid && out_tready && out_tuser[0] && !restart,
                  !out_tvalid || out_tdata[33:16] == 18'd0)

endmodule
